// ===== src/dpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_pkg
// shared widths, register map, state encoding and control structs for the
// depth pixel back-projection block
// ----------------------------------------------------------------------------
package dpb_pkg;

    // raster limits
    localparam int MAX_COLS  = 4096;
    localparam int MAX_ROWS  = 4096;
    localparam int CNT_W     = 12;

    // field widths
    localparam int DEPTH_W   = 18;
    localparam int COLOR_W   = 8;
    localparam int CENTER_W  = 16;
    localparam int RECIP_W   = 25;
    localparam int STRIDE_W  = 3;
    localparam int COORD_W   = 20;

    // arithmetic widths
    localparam int FRAC_PIX  = 4;                      // Q12.4 fraction bits
    localparam int PROD_W    = CENTER_W + DEPTH_W;     // |d| * z
    localparam int HALF_W    = PROD_W / 2;             // split for the recip multiply
    localparam int PART_W    = HALF_W + RECIP_W;       // one partial product
    localparam int ACC_W     = PROD_W + RECIP_W;       // full Q.28 product
    localparam int FRAC_W    = 28;                     // 4 + 24 fraction bits
    localparam int QUOT_W    = ACC_W + 1 - FRAC_W;
    localparam logic [COORD_W-1:0] SAT_HI  = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    // register port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    typedef enum logic [2:0] {
        REG_CENTER_COL = 3'd0,
        REG_CENTER_ROW = 3'd1,
        REG_RECIP_COL  = 3'd2,
        REG_RECIP_ROW  = 3'd3,
        REG_MIN_DEPTH  = 3'd4,
        REG_MAX_DEPTH  = 3'd5,
        REG_STRIDE     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [CENTER_W-1:0] center_col;
        logic [CENTER_W-1:0] center_row;
        logic [RECIP_W-1:0]  recip_col;
        logic [RECIP_W-1:0]  recip_row;
        logic [DEPTH_W-1:0]  min_depth;
        logic [DEPTH_W-1:0]  max_depth;
        logic [STRIDE_W-1:0] stride;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_LO,
        ST_HI,
        ST_RND,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic step_prod;
        logic step_lo;
        logic step_hi;
        logic step_rnd;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_result;
    } t_dp_status;

endpackage

// ===== src/dpb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_regs
// configuration register file behind a simple APB-style port
// ----------------------------------------------------------------------------
module dpb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpb_pkg::PADDR_W-1:0] paddr,
    input  logic [dpb_pkg::PDATA_W-1:0] pwdata,
    output logic [dpb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output dpb_pkg::t_cfg               o_cfg
);

    dpb_pkg::t_cfg     r_cfg;
    dpb_pkg::t_reg_idx w_idx;
    logic              w_write;

    assign w_idx   = dpb_pkg::t_reg_idx'(paddr[4:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_col <= dpb_pkg::CENTER_W'(5120);
            r_cfg.center_row <= dpb_pkg::CENTER_W'(3840);
            r_cfg.recip_col  <= dpb_pkg::RECIP_W'(33554);
            r_cfg.recip_row  <= dpb_pkg::RECIP_W'(33554);
            r_cfg.min_depth  <= dpb_pkg::DEPTH_W'(500);
            r_cfg.max_depth  <= dpb_pkg::DEPTH_W'(130000);
            r_cfg.stride     <= dpb_pkg::STRIDE_W'(3);
        end else if (w_write) begin
            unique case (w_idx)
                dpb_pkg::REG_CENTER_COL: r_cfg.center_col <= pwdata[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::REG_CENTER_ROW: r_cfg.center_row <= pwdata[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::REG_RECIP_COL:  r_cfg.recip_col  <= pwdata[dpb_pkg::RECIP_W-1:0];
                dpb_pkg::REG_RECIP_ROW:  r_cfg.recip_row  <= pwdata[dpb_pkg::RECIP_W-1:0];
                dpb_pkg::REG_MIN_DEPTH:  r_cfg.min_depth  <= pwdata[dpb_pkg::DEPTH_W-1:0];
                dpb_pkg::REG_MAX_DEPTH:  r_cfg.max_depth  <= pwdata[dpb_pkg::DEPTH_W-1:0];
                dpb_pkg::REG_STRIDE:     r_cfg.stride     <= pwdata[dpb_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            dpb_pkg::REG_CENTER_COL: prdata = dpb_pkg::PDATA_W'(r_cfg.center_col);
            dpb_pkg::REG_CENTER_ROW: prdata = dpb_pkg::PDATA_W'(r_cfg.center_row);
            dpb_pkg::REG_RECIP_COL:  prdata = dpb_pkg::PDATA_W'(r_cfg.recip_col);
            dpb_pkg::REG_RECIP_ROW:  prdata = dpb_pkg::PDATA_W'(r_cfg.recip_row);
            dpb_pkg::REG_MIN_DEPTH:  prdata = dpb_pkg::PDATA_W'(r_cfg.min_depth);
            dpb_pkg::REG_MAX_DEPTH:  prdata = dpb_pkg::PDATA_W'(r_cfg.max_depth);
            dpb_pkg::REG_STRIDE:     prdata = dpb_pkg::PDATA_W'(r_cfg.stride);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== src/dpb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_ctrl
// sequencer for one pixel request: capture, multiply steps, round, output load
// ----------------------------------------------------------------------------
module dpb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  dpb_pkg::t_dp_status i_status,
    output dpb_pkg::t_dp_cmd    o_cmd
);

    dpb_pkg::t_state r_state;
    dpb_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dpb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.need_result) begin
                        n_state = dpb_pkg::ST_PROD;
                    end
                end
            end
            dpb_pkg::ST_PROD: begin
                o_cmd.step_prod = 1'b1;
                n_state         = dpb_pkg::ST_LO;
            end
            dpb_pkg::ST_LO: begin
                o_cmd.step_lo = 1'b1;
                n_state       = dpb_pkg::ST_HI;
            end
            dpb_pkg::ST_HI: begin
                o_cmd.step_hi = 1'b1;
                n_state       = dpb_pkg::ST_RND;
            end
            dpb_pkg::ST_RND: begin
                o_cmd.step_rnd = 1'b1;
                n_state        = dpb_pkg::ST_LOAD;
            end
            dpb_pkg::ST_LOAD: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dpb_pkg::ST_IDLE;
                end
            end
            default: n_state = dpb_pkg::ST_IDLE;
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

// ===== src/dpb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_datapath
// raster counters, keep test, two-lane fixed-point projection, output register
// ----------------------------------------------------------------------------
module dpb_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dpb_pkg::t_dp_cmd                    i_cmd,
    output dpb_pkg::t_dp_status                 o_status,
    input  dpb_pkg::t_cfg                       i_cfg,
    input  logic [dpb_pkg::DEPTH_W-1:0]         i_depth_mm,
    input  logic [dpb_pkg::COLOR_W-1:0]         i_blue,
    input  logic [dpb_pkg::COLOR_W-1:0]         i_green,
    input  logic [dpb_pkg::COLOR_W-1:0]         i_red,
    input  logic                                i_end_of_line,
    input  logic                                i_end_of_frame,
    output logic signed [dpb_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [dpb_pkg::COORD_W-1:0]  o_point_y,
    output logic [dpb_pkg::DEPTH_W-1:0]         o_point_z,
    output logic [dpb_pkg::COLOR_W-1:0]         o_out_blue,
    output logic [dpb_pkg::COLOR_W-1:0]         o_out_green,
    output logic [dpb_pkg::COLOR_W-1:0]         o_out_red,
    output logic                                o_frame_done
);

    localparam int CW = dpb_pkg::CENTER_W;
    localparam int HW = dpb_pkg::HALF_W;
    localparam int PW = dpb_pkg::PROD_W;
    localparam int AW = dpb_pkg::ACC_W;
    localparam int QW = dpb_pkg::QUOT_W;
    localparam int OW = dpb_pkg::COORD_W;

    function automatic logic [dpb_pkg::STRIDE_W-1:0] next_phase(
        input logic [dpb_pkg::STRIDE_W-1:0] phase,
        input logic [dpb_pkg::STRIDE_W-1:0] stride
    );
        logic [dpb_pkg::STRIDE_W:0]   inc;
        logic [dpb_pkg::STRIDE_W-1:0] lim;
        inc = {1'b0, phase} + 1'b1;
        lim = (stride == '0) ? dpb_pkg::STRIDE_W'(1) : stride;
        return (inc >= {1'b0, lim}) ? '0 : inc[dpb_pkg::STRIDE_W-1:0];
    endfunction

    // round half away from zero on the magnitude, then saturate and apply sign
    function automatic logic [OW-1:0] round_sat(
        input logic [AW-1:0] acc,
        input logic          neg
    );
        logic [AW:0]   sum;
        logic [QW-1:0] q;
        logic [OW-1:0] mag;
        sum = {1'b0, acc} + ((AW + 1)'(1) << (dpb_pkg::FRAC_W - 1));
        q   = sum[AW:dpb_pkg::FRAC_W];
        if (!neg) begin
            return (q > QW'(dpb_pkg::SAT_HI)) ? dpb_pkg::SAT_HI : q[OW-1:0];
        end
        mag = (q > QW'(dpb_pkg::SAT_NEG)) ? dpb_pkg::SAT_NEG : q[OW-1:0];
        return OW'(0) - mag;
    endfunction

    // position state
    logic [dpb_pkg::CNT_W-1:0]    r_col_count;
    logic [dpb_pkg::CNT_W-1:0]    r_row_count;
    logic [dpb_pkg::STRIDE_W-1:0] r_col_phase;
    logic [dpb_pkg::STRIDE_W-1:0] r_row_phase;

    // captured pixel
    logic                         r_kept;
    logic                         r_eof;
    logic [dpb_pkg::DEPTH_W-1:0]  r_z;
    logic [dpb_pkg::COLOR_W-1:0]  r_blue;
    logic [dpb_pkg::COLOR_W-1:0]  r_green;
    logic [dpb_pkg::COLOR_W-1:0]  r_red;
    logic [CW-1:0]                r_mag_x;
    logic [CW-1:0]                r_mag_y;
    logic                         r_neg_x;
    logic                         r_neg_y;

    // arithmetic pipeline registers
    logic [PW-1:0]                r_prod_x;
    logic [PW-1:0]                r_prod_y;
    logic [AW-1:0]                r_acc_x;
    logic [AW-1:0]                r_acc_y;
    logic [OW-1:0]                r_pt_x;
    logic [OW-1:0]                r_pt_y;

    logic [CW-1:0]                w_pos_x;
    logic [CW-1:0]                w_pos_y;
    logic                         w_neg_x;
    logic                         w_neg_y;
    logic                         w_kept;
    logic [dpb_pkg::PART_W-1:0]   w_lo_x;
    logic [dpb_pkg::PART_W-1:0]   w_lo_y;
    logic [dpb_pkg::PART_W-1:0]   w_hi_x;
    logic [dpb_pkg::PART_W-1:0]   w_hi_y;

    assign w_pos_x = {r_col_count, {dpb_pkg::FRAC_PIX{1'b0}}};
    assign w_pos_y = {r_row_count, {dpb_pkg::FRAC_PIX{1'b0}}};
    assign w_neg_x = i_cfg.center_col > w_pos_x;
    assign w_neg_y = i_cfg.center_row > w_pos_y;
    assign w_kept  = (r_col_phase == '0) && (r_row_phase == '0) &&
                     (i_depth_mm >= i_cfg.min_depth) && (i_depth_mm <= i_cfg.max_depth);

    assign o_status.need_result = w_kept || i_end_of_frame;

    assign w_lo_x = dpb_pkg::PART_W'(r_prod_x[HW-1:0]) * dpb_pkg::PART_W'(i_cfg.recip_col);
    assign w_lo_y = dpb_pkg::PART_W'(r_prod_y[HW-1:0]) * dpb_pkg::PART_W'(i_cfg.recip_row);
    assign w_hi_x = dpb_pkg::PART_W'(r_prod_x[PW-1:HW]) * dpb_pkg::PART_W'(i_cfg.recip_col);
    assign w_hi_y = dpb_pkg::PART_W'(r_prod_y[PW-1:HW]) * dpb_pkg::PART_W'(i_cfg.recip_row);

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
        end else if (i_cmd.capture) begin
            if (i_end_of_frame) begin
                r_col_count <= '0;
                r_row_count <= '0;
                r_col_phase <= '0;
                r_row_phase <= '0;
            end else if (i_end_of_line) begin
                r_col_count <= '0;
                r_col_phase <= '0;
                r_row_count <= (r_row_count == dpb_pkg::CNT_W'(dpb_pkg::MAX_ROWS - 1)) ?
                               '0 : r_row_count + 1'b1;
                r_row_phase <= next_phase(r_row_phase, i_cfg.stride);
            end else begin
                r_col_count <= (r_col_count == dpb_pkg::CNT_W'(dpb_pkg::MAX_COLS - 1)) ?
                               '0 : r_col_count + 1'b1;
                r_col_phase <= next_phase(r_col_phase, i_cfg.stride);
            end
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kept  <= w_kept;
            r_eof   <= i_end_of_frame;
            r_z     <= i_depth_mm;
            r_blue  <= i_blue;
            r_green <= i_green;
            r_red   <= i_red;
            r_neg_x <= w_neg_x;
            r_neg_y <= w_neg_y;
            r_mag_x <= w_neg_x ? i_cfg.center_col - w_pos_x : w_pos_x - i_cfg.center_col;
            r_mag_y <= w_neg_y ? i_cfg.center_row - w_pos_y : w_pos_y - i_cfg.center_row;
        end
        if (i_cmd.step_prod) begin
            r_prod_x <= PW'(r_mag_x) * PW'(r_z);
            r_prod_y <= PW'(r_mag_y) * PW'(r_z);
        end
        if (i_cmd.step_lo) begin
            r_acc_x <= AW'(w_lo_x);
            r_acc_y <= AW'(w_lo_y);
        end
        if (i_cmd.step_hi) begin
            r_acc_x <= r_acc_x + (AW'(w_hi_x) << HW);
            r_acc_y <= r_acc_y + (AW'(w_hi_y) << HW);
        end
        if (i_cmd.step_rnd) begin
            r_pt_x <= round_sat(r_acc_x, r_neg_x);
            r_pt_y <= round_sat(r_acc_y, r_neg_y);
        end
        if (i_cmd.load_out) begin
            // dropped pixel that ends the frame gives an all-zero point
            o_point_x    <= r_kept ? r_pt_x : '0;
            o_point_y    <= r_kept ? r_pt_y : '0;
            o_point_z    <= r_kept ? r_z : '0;
            o_out_blue   <= r_kept ? r_blue : '0;
            o_out_green  <= r_kept ? r_green : '0;
            o_out_red    <= r_kept ? r_red : '0;
            o_frame_done <= r_eof;
        end
    end

endmodule

// ===== src/depth_pixel_backprojection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// back-projects a raster depth stream to colored 3-d points (pinhole model)
// ----------------------------------------------------------------------------
// sequence: a pixel that yields a point passes the product, low, high, round
//   and load states before it shows (longer if the output register is still full)
// requests: a pixel that yields nothing finishes in idle; a new request is not
//   taken until a point's multiply / round sequence through one datapath is done
// reset: synchronous active low; clears counters, sequencer and output valid,
//   and loads the configuration registers with their defaults
// ----------------------------------------------------------------------------
module depth_pixel_backprojection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // apb-style configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dpb_pkg::PADDR_W-1:0]         paddr,
    input  logic [dpb_pkg::PDATA_W-1:0]         pwdata,
    output logic [dpb_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,

    // pixel input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dpb_pkg::DEPTH_W-1:0]         i_depth_mm,
    input  logic [dpb_pkg::COLOR_W-1:0]         i_blue,
    input  logic [dpb_pkg::COLOR_W-1:0]         i_green,
    input  logic [dpb_pkg::COLOR_W-1:0]         i_red,
    input  logic                                i_end_of_line,
    input  logic                                i_end_of_frame,

    // point output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [dpb_pkg::COORD_W-1:0]  o_point_x,
    output logic signed [dpb_pkg::COORD_W-1:0]  o_point_y,
    output logic [dpb_pkg::DEPTH_W-1:0]         o_point_z,
    output logic [dpb_pkg::COLOR_W-1:0]         o_out_blue,
    output logic [dpb_pkg::COLOR_W-1:0]         o_out_green,
    output logic [dpb_pkg::COLOR_W-1:0]         o_out_red,
    output logic                                o_frame_done
);

    // live configuration; the user keeps it stable while pixels are in flight, the block does not enforce it
    dpb_pkg::t_cfg       w_cfg;
    // sequencer commands and datapath status
    dpb_pkg::t_dp_cmd    w_cmd;
    dpb_pkg::t_dp_status w_status;

    // register file: center point Q12.4, focal reciprocals Q1.24, depth window,
    // decimation stride
    dpb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: takes a request in idle; a pixel that is dropped and does
    // not close the frame finishes right there, anything else walks the
    // product, low partial, high partial, round and output load steps
    dpb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath: x and y lanes run side by side
    //   |d| * z            16x18 multiply
    //   low half * 1/f     17x25 multiply
    //   high half * 1/f    17x25 multiply, shifted and accumulated
    //   round half away from zero, saturate to 20 bits, restore sign
    dpb_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg          (w_cfg),
        .i_depth_mm     (i_depth_mm),
        .i_blue         (i_blue),
        .i_green        (i_green),
        .i_red          (i_red),
        .i_end_of_line  (i_end_of_line),
        .i_end_of_frame (i_end_of_frame),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_z      (o_point_z),
        .o_out_blue     (o_out_blue),
        .o_out_green    (o_out_green),
        .o_out_red      (o_out_red),
        .o_frame_done   (o_frame_done)
    );

endmodule

// ===== src/dpb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_checker
// port-level checks on the back-projection block, bound to the top level
// ----------------------------------------------------------------------------
module dpb_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                pready,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [dpb_pkg::COORD_W-1:0]  o_point_x,
    input  logic signed [dpb_pkg::COORD_W-1:0]  o_point_y,
    input  logic [dpb_pkg::DEPTH_W-1:0]         o_point_z,
    input  logic [dpb_pkg::COLOR_W-1:0]         o_out_blue,
    input  logic [dpb_pkg::COLOR_W-1:0]         o_out_green,
    input  logic [dpb_pkg::COLOR_W-1:0]         o_out_red,
    input  logic                                o_frame_done
);

    // a stalled point stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // a stalled point keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_point_x) && $stable(o_point_y) && $stable(o_point_z) &&
            $stable(o_out_blue) && $stable(o_out_green) && $stable(o_out_red) &&
            $stable(o_frame_done))
        else $error("output payload changed while stalled");

    // a new point never follows a request taken in the cycle before
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready))
        else $error("point appeared one cycle after a request");

    // while the sequencer works on a point it takes no new request
    a_busy_after_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready, 2))
        else $error("request taken during projection");

    // register port never inserts wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);
